>>> sv/urbfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared sizes, action codes and register indexes for the UART ring buffer
// with frame resynchronization.
// ----------------------------------------------------------------------------
package urbfs_pkg;

  localparam int RX_DEPTH  = 32;
  localparam int TX_DEPTH  = 32;
  localparam int FRAME_LEN = 8;
  localparam int TRIM_KEEP = 15;

  localparam int RX_IDX_W  = $clog2(RX_DEPTH);
  localparam int TX_IDX_W  = $clog2(TX_DEPTH);
  localparam int BYTE_W    = 8;
  localparam int ERR_W     = 4;
  localparam int FILL_W    = 5;
  localparam int ACT_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 4'b1000;

  localparam logic [ACT_W-1:0] ACT_RX_BYTE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TX_READY = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COUNT    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TRIM     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESYNC   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 1'd1;

  localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'd83;
  localparam logic [BYTE_W-1:0] END_CHAR_RESET   = 8'd69;

endpackage

>>> sv/uart_ring_buffer_frame_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer with frame resynchronization
// Receive and transmit byte rings in two RAMs, a sticky line error mask and a
// resync walker dropping receive bytes until a frame leads or too few remain.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Contents
//  in        in_valid / in_stall   action, line_byte, error bits, send_byte
//  out       out_valid / out_stall read_byte, error_mask, status, fill_count
//  cfg       cfg_valid / cfg_ready cfg_index, cfg_data (start and end chars)
//
// One request is handled at a time; a new one is taken once the last result
// has been issued. A read or tx_ready that finds data passes a data state to
// fetch its byte. Resync ends once less than a frame is held; else it checks
// the head for the start char and the frame's last byte for the end char,
// dropping a byte on each mismatch. Reset clears indexes, the error mask and
// the transmitter flag; the RAMs need no clearing. While a result is stalled,
// the next request runs up to its last state and waits there.
// ----------------------------------------------------------------------------
module uart_ring_buffer_frame_sync (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [urbfs_pkg::ACT_W-1:0]         action,
  input  logic [urbfs_pkg::BYTE_W-1:0]        line_byte,
  input  logic                                framing_error,
  input  logic                                overrun_error,
  input  logic                                parity_error,
  input  logic [urbfs_pkg::BYTE_W-1:0]        send_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [urbfs_pkg::BYTE_W-1:0]        read_byte,
  output logic [urbfs_pkg::ERR_W-1:0]         error_mask,
  output logic                                no_data,
  output logic                                send_rejected,
  output logic                                send_valid,
  output logic                                transmitter_armed,
  output logic                                frame_ready,
  output logic [urbfs_pkg::FILL_W-1:0]        fill_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [urbfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [urbfs_pkg::BYTE_W-1:0]        cfg_data
);

  localparam int RXW = urbfs_pkg::RX_IDX_W;
  localparam int TXW = urbfs_pkg::TX_IDX_W;
  localparam int BW  = urbfs_pkg::BYTE_W;
  localparam int EW  = urbfs_pkg::ERR_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_RDATA    = 3'd2;
  localparam logic [2:0] ST_TDATA    = 3'd3;
  localparam logic [2:0] ST_RS_CHECK = 3'd4;
  localparam logic [2:0] ST_RS_HEAD  = 3'd5;
  localparam logic [2:0] ST_RS_TAIL  = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0]                     state;
  logic [urbfs_pkg::ACT_W-1:0]    act;
  logic [BW-1:0]                  line_q;
  logic [2:0]                     err_q;
  logic [BW-1:0]                  send_q;
  logic [RXW-1:0]                 rx_wr;
  logic [RXW-1:0]                 rx_rd;
  logic [TXW-1:0]                 tx_wr;
  logic [TXW-1:0]                 tx_rd;
  logic [EW-1:0]                  sticky;
  logic                           tx_armed;
  logic [BW-1:0]                  start_char;
  logic [BW-1:0]                  end_char;
  logic                           rs_scan;

  logic [BW-1:0]                  res_byte;
  logic [EW-1:0]                  res_mask;
  logic                           res_nodata;
  logic                           res_rejected;
  logic                           res_valid;
  logic                           res_ready;

  logic [RXW-1:0]                 rx_wr_inc;
  logic [TXW-1:0]                 tx_wr_inc;
  logic                           rx_full;
  logic                           tx_full;
  logic [RXW-1:0]                 rx_fill;
  logic                           rx_we;
  logic                           tx_we;
  logic [RXW-1:0]                 rx_raddr;
  logic [TXW-1:0]                 tx_raddr;
  logic [BW-1:0]                  rx_q;
  logic [BW-1:0]                  tx_q;
  logic                           out_free;

  assign rx_wr_inc = rx_wr + RXW'(1);
  assign tx_wr_inc = tx_wr + TXW'(1);
  assign rx_full   = (rx_wr_inc == rx_rd);
  assign tx_full   = (tx_wr_inc == tx_rd);
  assign rx_fill   = rx_wr - rx_rd;
  assign rx_we     = (state == ST_EXEC) && (act == urbfs_pkg::ACT_RX_BYTE) && !rx_full;
  assign tx_we     = (state == ST_EXEC) && (act == urbfs_pkg::ACT_WRITE) && !tx_full;
  assign tx_raddr  = tx_rd + TXW'(1);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    rx_raddr = rx_rd + RXW'(1);
    if (state == ST_RS_HEAD) begin
      if ((rx_q == start_char) && !rs_scan) begin
        rx_raddr = rx_rd + RXW'(urbfs_pkg::FRAME_LEN);
      end else begin
        rx_raddr = rx_rd + RXW'(2);
      end
    end
  end

  urbfs_ram #(.WIDTH(BW), .DEPTH(urbfs_pkg::RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr_inc),
    .wdata (line_q),
    .raddr (rx_raddr),
    .rdata (rx_q)
  );

  urbfs_ram #(.WIDTH(BW), .DEPTH(urbfs_pkg::TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr_inc),
    .wdata (send_q),
    .raddr (tx_raddr),
    .rdata (tx_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= urbfs_pkg::START_CHAR_RESET;
      end_char   <= urbfs_pkg::END_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        urbfs_pkg::REG_START_CHAR: start_char <= cfg_data;
        urbfs_pkg::REG_END_CHAR:   end_char   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act    <= action;
      line_q <= line_byte;
      err_q  <= {parity_error, overrun_error, framing_error};
      send_q <= send_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rx_wr     <= '0;
      rx_rd     <= '0;
      tx_wr     <= '0;
      tx_rd     <= '0;
      sticky    <= '0;
      tx_armed  <= 1'b0;
      rs_scan   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_byte     <= '0;
          res_mask     <= ((act == urbfs_pkg::ACT_READ) && (rx_wr != rx_rd)) ? sticky : '0;
          res_nodata   <= (act == urbfs_pkg::ACT_READ) && (rx_wr == rx_rd);
          res_rejected <= (act == urbfs_pkg::ACT_WRITE) && tx_full;
          res_valid    <= (act == urbfs_pkg::ACT_TX_READY) && (tx_wr != tx_rd);
          res_ready    <= 1'b0;
          rs_scan      <= 1'b0;
          case (act)
            urbfs_pkg::ACT_RX_BYTE: begin
              state <= ST_DONE;
              if (rx_full) begin
                sticky <= sticky | urbfs_pkg::ERR_OVERFLOW;
              end else begin
                rx_wr  <= rx_wr_inc;
                sticky <= sticky | {1'b0, err_q};
              end
            end
            urbfs_pkg::ACT_READ: begin
              if (rx_wr == rx_rd) begin
                state <= ST_DONE;
              end else begin
                rx_rd  <= rx_rd + RXW'(1);
                sticky <= '0;
                state  <= ST_RDATA;
              end
            end
            urbfs_pkg::ACT_WRITE: begin
              state <= ST_DONE;
              if (!tx_full) begin
                tx_wr    <= tx_wr_inc;
                tx_armed <= 1'b1;
              end
            end
            urbfs_pkg::ACT_TX_READY: begin
              if (tx_wr != tx_rd) begin
                tx_rd <= tx_rd + TXW'(1);
                state <= ST_TDATA;
              end else begin
                tx_armed <= 1'b0;
                state    <= ST_DONE;
              end
            end
            urbfs_pkg::ACT_TRIM: begin
              state <= ST_DONE;
              if ((rx_fill > RXW'(urbfs_pkg::RX_DEPTH / 2)) &&
                  (rx_fill > RXW'(urbfs_pkg::TRIM_KEEP))) begin
                rx_rd <= rx_wr - RXW'(urbfs_pkg::TRIM_KEEP);
              end
            end
            urbfs_pkg::ACT_RESYNC: begin
              state <= ST_RS_CHECK;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_RDATA: begin
          res_byte <= rx_q;
          state    <= ST_DONE;
        end
        ST_TDATA: begin
          res_byte <= tx_q;
          state    <= ST_DONE;
        end
        ST_RS_CHECK: begin
          if (rx_fill < RXW'(urbfs_pkg::FRAME_LEN)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_RS_HEAD;
          end
        end
        ST_RS_HEAD: begin
          if (rx_q == start_char) begin
            if (rs_scan) begin
              rs_scan <= 1'b0;
              state   <= ST_RS_CHECK;
            end else begin
              state <= ST_RS_TAIL;
            end
          end else begin
            rx_rd   <= rx_rd + RXW'(1);
            rs_scan <= 1'b1;
            if ((rx_rd + RXW'(1)) == rx_wr) begin
              state <= ST_DONE;
            end
          end
        end
        ST_RS_TAIL: begin
          if (rx_q == end_char) begin
            res_ready <= 1'b1;
            state     <= ST_DONE;
          end else begin
            rx_rd <= rx_rd + RXW'(1);
            state <= ST_RS_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      read_byte         <= res_byte;
      error_mask        <= res_mask;
      no_data           <= res_nodata;
      send_rejected     <= res_rejected;
      send_valid        <= res_valid;
      transmitter_armed <= tx_armed;
      frame_ready       <= res_ready;
      fill_count        <= urbfs_pkg::FILL_W'(rx_fill);
    end
  end

`ifndef SYNTHESIS
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared without passing the done state");

  a_armed_when_pending: assert property (@(posedge clk) disable iff (rst)
    (tx_wr != tx_rd) |-> tx_armed)
    else $error("transmit ring holds bytes while the transmitter is disarmed");

  a_frame_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_ready) |-> (fill_count >= urbfs_pkg::FILL_W'(urbfs_pkg::FRAME_LEN)))
    else $error("frame reported with fewer bytes than a frame");
`endif

endmodule

>>> sv/urbfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module urbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
